// ----- hdl/saar_pkg.sv -----
// Shared types, constants and helpers for the swept box axis resolver.
package saar_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int POS_W       = 32;
  localparam int SIZE_W      = 24;
  localparam int HALF_W      = SIZE_W - 1;
  localparam int WIDE_W      = POS_W + 3;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_SOLID = 2'd1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_SCAN,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic                     op;
    logic [3:0]               slot;
    logic signed [POS_W-1:0]  old_x;
    logic signed [POS_W-1:0]  old_y;
    logic signed [POS_W-1:0]  old_z;
    logic signed [POS_W-1:0]  move_x;
    logic signed [POS_W-1:0]  move_y;
    logic signed [POS_W-1:0]  move_z;
    logic [SIZE_W-1:0]        size_x;
    logic [SIZE_W-1:0]        size_y;
    logic [SIZE_W-1:0]        size_z;
    logic [1:0]               kind;
  } in_item_t;

  typedef struct packed {
    logic                     is_final;
    logic [3:0]               hit_slot;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic                     hit_on_x;
    logic                     hit_on_y;
    logic                     hit_on_z;
    logic                     last;
  } res_item_t;

  // One stored box: predicted centre and half sizes
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [HALF_W-1:0]       half_x;
    logic [HALF_W-1:0]       half_y;
    logic [HALF_W-1:0]       half_z;
  } entry_t;

  // Verdict of one entry test
  typedef struct packed {
    logic                    hit;
    logic signed [POS_W-1:0] new_pos;
  } eval_t;

  function automatic logic signed [WIDE_W-1:0] wide_p(input logic signed [POS_W-1:0] p);
    return {{(WIDE_W-POS_W){p[POS_W-1]}}, p};
  endfunction

  function automatic logic signed [WIDE_W-1:0] wide_h(input logic [HALF_W-1:0] h);
    return {{(WIDE_W-HALF_W){1'b0}}, h};
  endfunction

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = wide_p({1'b0, {(POS_W-1){1'b1}}});
    lo = wide_p({1'b1, {(POS_W-1){1'b0}}});
    if (v > hi) return hi[POS_W-1:0];
    else if (v < lo) return lo[POS_W-1:0];
    else return v[POS_W-1:0];
  endfunction

endpackage

// ----- hdl/saar_eval.sv -----
// Test of one stored box against the mover on the current axis.
module saar_eval (
  input  logic [1:0]                       axis,
  input  logic signed [saar_pkg::POS_W-1:0] mv_pos [3],
  input  logic [saar_pkg::HALF_W-1:0]       mv_half [3],
  input  logic signed [saar_pkg::POS_W-1:0] old_main,
  input  logic                              both_solid,
  input  saar_pkg::entry_t                  ent,
  output saar_pkg::eval_t                   res
);

  logic signed [saar_pkg::WIDE_W-1:0] ep [3];
  logic signed [saar_pkg::WIDE_W-1:0] eh [3];
  logic signed [saar_pkg::WIDE_W-1:0] mp [3];
  logic signed [saar_pkg::WIDE_W-1:0] mh [3];
  logic signed [saar_pkg::WIDE_W-1:0] om;
  logic signed [saar_pkg::WIDE_W-1:0] p, h, e, d, lo_face, hi_face;
  logic [1:0] b, c;
  logic cross_ok;

  // Widen both boxes
  always_comb begin
    ep[0] = saar_pkg::wide_p(ent.pos_x);
    ep[1] = saar_pkg::wide_p(ent.pos_y);
    ep[2] = saar_pkg::wide_p(ent.pos_z);
    eh[0] = saar_pkg::wide_h(ent.half_x);
    eh[1] = saar_pkg::wide_h(ent.half_y);
    eh[2] = saar_pkg::wide_h(ent.half_z);
    for (int k = 0; k < 3; k++) begin
      mp[k] = saar_pkg::wide_p(mv_pos[k]);
      mh[k] = saar_pkg::wide_h(mv_half[k]);
    end
    om = saar_pkg::wide_p(old_main);
  end

  // Strict overlap on both cross axes, then face crossing or plain overlap
  always_comb begin
    b = (axis == saar_pkg::AXIS_X) ? saar_pkg::AXIS_Y : saar_pkg::AXIS_X;
    c = (axis == saar_pkg::AXIS_Z) ? saar_pkg::AXIS_Y : saar_pkg::AXIS_Z;
    cross_ok = (mp[b] - mh[b] < ep[b] + eh[b]) && (mp[b] + mh[b] > ep[b] - eh[b]) &&
               (mp[c] - mh[c] < ep[c] + eh[c]) && (mp[c] + mh[c] > ep[c] - eh[c]);
    p = mp[axis];
    h = mh[axis];
    e = ep[axis];
    d = eh[axis];
    lo_face = e - d;
    hi_face = e + d;
    res.hit = 1'b0;
    res.new_pos = mv_pos[axis];
    if (cross_ok) begin
      if (both_solid) begin
        if ((om + h <= lo_face) && (p + h > lo_face)) begin
          res.hit = 1'b1;
          res.new_pos = saar_pkg::sat32(lo_face - h);
        end else if ((om - h >= hi_face) && (p - h < hi_face)) begin
          res.hit = 1'b1;
          res.new_pos = saar_pkg::sat32(hi_face + h);
        end
      end else if ((p - h < hi_face) && (p + h > lo_face)) begin
        res.hit = 1'b1;
      end
    end
  end

endmodule

// ----- hdl/swept_aabb_axis_resolver.sv -----
// Top level of the swept box resolver: entry table, axis sequencer and result register.
//
// A load beat writes one table entry and returns nothing. A check beat moves the box
// along X, Y and Z in turn; each axis has a move step and then a scan of all 16 table
// entries, as the entry memory is read one slot per cycle unless a hit report stalls
// on a full result register. Each newly hit slot is reported once, in the order found,
// followed by a final beat with the resolved centre and axis flags. An inactive mover
// moves without a scan and gives only the final beat.
module swept_aabb_axis_resolver (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  saar_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output saar_pkg::res_item_t  out_data
);

  saar_pkg::state_t state_r, state_nxt;
  logic [1:0]                          axis_r;
  logic [saar_pkg::IDX_W-1:0]          idx_r, idx_nxt;
  logic signed [saar_pkg::POS_W-1:0]   pos_r [3];
  logic signed [saar_pkg::POS_W-1:0]   old_r [3];
  logic signed [saar_pkg::POS_W-1:0]   mv_r [3];
  logic [saar_pkg::HALF_W-1:0]         half_r [3];
  logic [1:0]                          kind_mv_r;
  logic [3:0]                          self_r;
  logic [saar_pkg::NUM_ENTRIES-1:0]    mask_r;
  logic [2:0]                          flag_r;
  logic                                out_valid_r;
  saar_pkg::res_item_t                 out_data_r;
  saar_pkg::res_item_t                 hit_word;
  logic [1:0]                          kind_r [saar_pkg::NUM_ENTRIES];
  saar_pkg::entry_t                    mem [saar_pkg::NUM_ENTRIES];
  saar_pkg::entry_t                    rd_r;
  saar_pkg::entry_t                    wr_word;
  saar_pkg::eval_t                     ev;

  logic accept, wr_en, out_free, active, hit_new, stall, advance, last_idx, mv_none;
  logic load_hit, load_final, move_step;
  logic signed [saar_pkg::POS_W-1:0] moved;

  assign accept    = in_valid && in_ready;
  assign wr_en     = accept && (in_data.op == saar_pkg::OP_LOAD) &&
                     ({1'b0, in_data.slot} < 5'(saar_pkg::NUM_ENTRIES));
  assign out_free  = !out_valid_r || out_ready;
  assign mv_none   = (kind_mv_r == saar_pkg::KIND_NONE);
  assign active    = ({1'b0, idx_r} != {1'b0, self_r}) &&
                     (kind_r[idx_r] != saar_pkg::KIND_NONE);
  assign hit_new   = (state_r == saar_pkg::ST_SCAN) && active && ev.hit && !mask_r[idx_r];
  assign stall     = hit_new && !out_free;
  assign advance   = !stall;
  assign last_idx  = (idx_r == saar_pkg::IDX_W'(saar_pkg::NUM_ENTRIES - 1));
  assign moved     = saar_pkg::sat32(saar_pkg::wide_p(pos_r[axis_r]) +
                                     saar_pkg::wide_p(mv_r[axis_r]));

  // Entry word for a load
  always_comb begin
    wr_word.pos_x  = saar_pkg::sat32(saar_pkg::wide_p(in_data.old_x) +
                                     saar_pkg::wide_p(in_data.move_x));
    wr_word.pos_y  = saar_pkg::sat32(saar_pkg::wide_p(in_data.old_y) +
                                     saar_pkg::wide_p(in_data.move_y));
    wr_word.pos_z  = saar_pkg::sat32(saar_pkg::wide_p(in_data.old_z) +
                                     saar_pkg::wide_p(in_data.move_z));
    wr_word.half_x = in_data.size_x[saar_pkg::SIZE_W-1:1];
    wr_word.half_y = in_data.size_y[saar_pkg::SIZE_W-1:1];
    wr_word.half_z = in_data.size_z[saar_pkg::SIZE_W-1:1];
  end

  // Hit report word for the current entry
  always_comb begin
    hit_word          = '0;
    hit_word.hit_slot = 4'(idx_r);
  end

  // Entry memory: one write port, registered read at the next scan index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_data.slot[saar_pkg::IDX_W-1:0]] <= wr_word;
    end
    rd_r <= mem[idx_nxt];
  end

  // Entry kinds live in flops so that reset clears the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < saar_pkg::NUM_ENTRIES; k++) kind_r[k] <= saar_pkg::KIND_NONE;
    end else if (wr_en) begin
      kind_r[in_data.slot[saar_pkg::IDX_W-1:0]] <= in_data.kind;
    end
  end

  saar_eval u_eval (
    .axis       (axis_r),
    .mv_pos     (pos_r),
    .mv_half    (half_r),
    .old_main   (old_r[axis_r]),
    .both_solid ((kind_mv_r == saar_pkg::KIND_SOLID) &&
                 (kind_r[idx_r] == saar_pkg::KIND_SOLID)),
    .ent        (rd_r),
    .res        (ev)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      saar_pkg::ST_IDLE: begin
        if (accept && (in_data.op == saar_pkg::OP_CHECK)) state_nxt = saar_pkg::ST_MOVE;
      end
      saar_pkg::ST_MOVE: begin
        if (!mv_none) state_nxt = saar_pkg::ST_SCAN;
        else if (axis_r == saar_pkg::AXIS_Z) state_nxt = saar_pkg::ST_FINAL;
      end
      saar_pkg::ST_SCAN: begin
        if (advance && last_idx) begin
          state_nxt = (axis_r == saar_pkg::AXIS_Z) ? saar_pkg::ST_FINAL : saar_pkg::ST_MOVE;
        end
      end
      saar_pkg::ST_FINAL: begin
        if (out_free) state_nxt = saar_pkg::ST_IDLE;
      end
      default: state_nxt = saar_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready   = 1'b0;
    load_hit   = 1'b0;
    load_final = 1'b0;
    move_step  = 1'b0;
    idx_nxt    = idx_r;
    unique case (state_r)
      saar_pkg::ST_IDLE:  in_ready = 1'b1;
      saar_pkg::ST_MOVE: begin
        move_step = 1'b1;
        idx_nxt   = '0;
      end
      saar_pkg::ST_SCAN: begin
        load_hit = hit_new && out_free;
        if (advance) idx_nxt = idx_r + 1'b1;
      end
      saar_pkg::ST_FINAL: load_final = out_free;
      default: ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= saar_pkg::ST_IDLE;
      axis_r  <= saar_pkg::AXIS_X;
      idx_r   <= '0;
      mask_r  <= '0;
      flag_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (accept && (in_data.op == saar_pkg::OP_CHECK)) begin
        axis_r <= saar_pkg::AXIS_X;
        mask_r <= '0;
        flag_r <= '0;
      end else if (move_step && mv_none && (axis_r != saar_pkg::AXIS_Z)) begin
        axis_r <= axis_r + 2'd1;
      end else if ((state_r == saar_pkg::ST_SCAN) && advance) begin
        if (active && ev.hit) begin
          mask_r[idx_r] <= 1'b1;
          if ((axis_r != saar_pkg::AXIS_Y) || (kind_r[idx_r] == saar_pkg::KIND_SOLID)) begin
            flag_r[axis_r] <= 1'b1;
          end
        end
        if (last_idx && (axis_r != saar_pkg::AXIS_Z)) axis_r <= axis_r + 2'd1;
      end
    end
  end

  // Mover payload: capture, move along the axis, clamp on hits
  always_ff @(posedge clk) begin
    if (accept && (in_data.op == saar_pkg::OP_CHECK)) begin
      pos_r[0]  <= in_data.old_x;
      pos_r[1]  <= in_data.old_y;
      pos_r[2]  <= in_data.old_z;
      old_r[0]  <= in_data.old_x;
      old_r[1]  <= in_data.old_y;
      old_r[2]  <= in_data.old_z;
      mv_r[0]   <= in_data.move_x;
      mv_r[1]   <= in_data.move_y;
      mv_r[2]   <= in_data.move_z;
      half_r[0] <= in_data.size_x[saar_pkg::SIZE_W-1:1];
      half_r[1] <= in_data.size_y[saar_pkg::SIZE_W-1:1];
      half_r[2] <= in_data.size_z[saar_pkg::SIZE_W-1:1];
      kind_mv_r <= in_data.kind;
      self_r    <= in_data.slot;
    end else if (move_step) begin
      pos_r[axis_r] <= moved;
    end else if ((state_r == saar_pkg::ST_SCAN) && advance && active && ev.hit) begin
      pos_r[axis_r] <= ev.new_pos;
    end
  end

  // Result register: hold a beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_hit || load_final) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_hit) begin
      out_data_r <= hit_word;
    end else if (load_final) begin
      out_data_r.is_final <= 1'b1;
      out_data_r.hit_slot <= '0;
      out_data_r.pos_x    <= pos_r[0];
      out_data_r.pos_y    <= pos_r[1];
      out_data_r.pos_z    <= pos_r[2];
      out_data_r.hit_on_x <= flag_r[0];
      out_data_r.hit_on_y <= flag_r[1];
      out_data_r.hit_on_z <= flag_r[2];
      out_data_r.last     <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A stalled hit report keeps the scan on the same entry
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == saar_pkg::ST_SCAN) && stall |=> $stable(idx_r) && (state_r == saar_pkg::ST_SCAN))
    else $error("scan moved on while a hit report was stalled");

  // A pending hit report always names a slot already marked as reported
  a_hit_marked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.is_final && (state_r != saar_pkg::ST_IDLE) |->
      mask_r[out_data_r.hit_slot[saar_pkg::IDX_W-1:0]])
    else $error("hit report for an unmarked slot");

  // No new item is taken while a check is in progress
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != saar_pkg::ST_IDLE) |-> !in_ready)
    else $error("input taken during a check");

endmodule

// ----- verif/tb_swept_aabb_axis_resolver.sv -----
// Testbench for the swept box axis resolver: directed table, random loads and checks, scoreboard.
`timescale 1ns / 100ps

module tb_swept_aabb_axis_resolver;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 80;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  saar_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  saar_pkg::res_item_t out_data;

  swept_aabb_axis_resolver u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Shadow of the box table
  longint    box_pos  [3][saar_pkg::NUM_ENTRIES];
  longint    box_half [3][saar_pkg::NUM_ENTRIES];
  bit [1:0]  box_kind [saar_pkg::NUM_ENTRIES];
  bit [15:0] seen_mask;

  saar_pkg::res_item_t expected_beats[$];
  int        fail_count;
  int        cycle_count;
  bit        calm;        // no idling on either side
  int        hold_off;    // cycles the receiver must still refuse

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic saar_pkg::res_item_t hit_beat(int s);
    saar_pkg::res_item_t r;
    r = '0;
    r.hit_slot = s[3:0];
    return r;
  endfunction

  // Sweep one axis against the table; appends hit reports, returns the axis flag
  function automatic bit sweep_axis(int a, ref longint pos[3], input longint half[3],
                                    input longint old_main, input bit mover_solid,
                                    input int self, input bit solid_only);
    int b, c;
    bit flag, hit;
    longint dm, dh;
    b = (a == 0) ? 1 : 0;
    c = (a == 2) ? 1 : 2;
    flag = 1'b0;
    for (int i = 0; i < saar_pkg::NUM_ENTRIES; i++) begin
      if (i == self || box_kind[i] == saar_pkg::KIND_NONE) continue;
      if (!(pos[b] - half[b] < box_pos[b][i] + box_half[b][i] &&
            pos[b] + half[b] > box_pos[b][i] - box_half[b][i] &&
            pos[c] - half[c] < box_pos[c][i] + box_half[c][i] &&
            pos[c] + half[c] > box_pos[c][i] - box_half[c][i])) continue;
      dm  = box_pos[a][i];
      dh  = box_half[a][i];
      hit = 1'b0;
      if (mover_solid && box_kind[i] == saar_pkg::KIND_SOLID) begin
        if (old_main + half[a] <= dm - dh && pos[a] + half[a] > dm - dh) begin
          pos[a] = clamp32(dm - dh - half[a]);
          hit = 1'b1;
        end else if (old_main - half[a] >= dm + dh && pos[a] - half[a] < dm + dh) begin
          pos[a] = clamp32(dm + dh + half[a]);
          hit = 1'b1;
        end
      end else if (pos[a] - half[a] < dm + dh && pos[a] + half[a] > dm - dh) begin
        hit = 1'b1;
      end
      if (hit) begin
        if (!seen_mask[i]) begin
          seen_mask[i] = 1'b1;
          expected_beats.push_back(hit_beat(i));
        end
        if (!solid_only || box_kind[i] == saar_pkg::KIND_SOLID) flag = 1'b1;
      end
    end
    return flag;
  endfunction

  // Advance the shadow table and queue the beats this item causes
  task automatic resolve_item(saar_pkg::in_item_t it);
    longint old_c[3], mv[3], half[3], pos[3];
    saar_pkg::res_item_t fin;
    bit hx, hy, hz;
    old_c = '{longint'(it.old_x), longint'(it.old_y), longint'(it.old_z)};
    mv    = '{longint'(it.move_x), longint'(it.move_y), longint'(it.move_z)};
    half  = '{longint'(it.size_x >> 1), longint'(it.size_y >> 1), longint'(it.size_z >> 1)};
    if (it.op == saar_pkg::OP_LOAD) begin
      for (int a = 0; a < 3; a++) begin
        box_pos[a][it.slot]  = clamp32(old_c[a] + mv[a]);
        box_half[a][it.slot] = half[a];
      end
      box_kind[it.slot] = it.kind;
      return;
    end
    seen_mask = '0;
    hx = 0; hy = 0; hz = 0;
    pos = old_c;
    if (it.kind == saar_pkg::KIND_NONE) begin
      for (int a = 0; a < 3; a++) pos[a] = clamp32(old_c[a] + mv[a]);
    end else begin
      pos[0] = clamp32(pos[0] + mv[0]);
      hx = sweep_axis(0, pos, half, old_c[0], it.kind == saar_pkg::KIND_SOLID, it.slot, 1'b0);
      pos[1] = clamp32(pos[1] + mv[1]);
      hy = sweep_axis(1, pos, half, old_c[1], it.kind == saar_pkg::KIND_SOLID, it.slot, 1'b1);
      pos[2] = clamp32(pos[2] + mv[2]);
      hz = sweep_axis(2, pos, half, old_c[2], it.kind == saar_pkg::KIND_SOLID, it.slot, 1'b0);
    end
    fin = '0;
    fin.is_final = 1'b1;
    fin.last     = 1'b1;
    fin.pos_x    = pos[0][31:0];
    fin.pos_y    = pos[1][31:0];
    fin.pos_z    = pos[2][31:0];
    fin.hit_on_x = hx;
    fin.hit_on_y = hy;
    fin.hit_on_z = hz;
    expected_beats.push_back(fin);
  endtask

  function automatic saar_pkg::in_item_t make_item(bit op, int s, longint ox, longint oy,
                                                   longint oz, longint mx, longint my,
                                                   longint mz, int sx, int sy, int sz,
                                                   int k);
    saar_pkg::in_item_t it;
    it.op = op; it.slot = s[3:0];
    it.old_x = ox[31:0]; it.old_y = oy[31:0]; it.old_z = oz[31:0];
    it.move_x = mx[31:0]; it.move_y = my[31:0]; it.move_z = mz[31:0];
    it.size_x = sx[23:0]; it.size_y = sy[23:0]; it.size_z = sz[23:0];
    it.kind = k[1:0];
    return it;
  endfunction

  // Random item; mostly boxes clustered near the origin so that they touch
  function automatic saar_pkg::in_item_t random_item(bit op, int k);
    saar_pkg::in_item_t it;
    logic [287:0] raw;
    int span;
    span = ($urandom_range(0, 9) == 0) ? 0 : 4096;
    if (span == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
      it = raw[$bits(saar_pkg::in_item_t)-1:0];
      it.op = op;
      it.kind = k[1:0];
      return it;
    end
    it = make_item(op, $urandom_range(0, 15),
                   longint'($urandom_range(0, 2*span)) - span,
                   longint'($urandom_range(0, 2*span)) - span,
                   longint'($urandom_range(0, 2*span)) - span,
                   longint'($urandom_range(0, span)) - span/2,
                   longint'($urandom_range(0, span)) - span/2,
                   longint'($urandom_range(0, span)) - span/2,
                   $urandom_range(1, 2048), $urandom_range(1, 2048),
                   $urandom_range(1, 2048), k);
    return it;
  endfunction

  // Offer one beat and wait for it to be taken; valid drops only while idling
  task automatic send_beat(saar_pkg::in_item_t it, bit allow_idle);
    while (allow_idle && !calm && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    resolve_item(it);
  endtask

  // Receiver: random stalls, and a single long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off  <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 30);
    end
  end

  // Compare each accepted beat with the oldest expectation
  always @(posedge clk) begin
    saar_pkg::res_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat %p", out_data);
        fail_count++;
      end else begin
        e = expected_beats.pop_front();
        if (out_data.is_final !== e.is_final) begin
          $error("is_final exp %0d got %0d", e.is_final, out_data.is_final); fail_count++; end
        if (out_data.hit_slot !== e.hit_slot) begin
          $error("hit_slot exp %0d got %0d", e.hit_slot, out_data.hit_slot); fail_count++; end
        if (out_data.pos_x !== e.pos_x) begin
          $error("pos_x exp %0d got %0d", e.pos_x, out_data.pos_x); fail_count++; end
        if (out_data.pos_y !== e.pos_y) begin
          $error("pos_y exp %0d got %0d", e.pos_y, out_data.pos_y); fail_count++; end
        if (out_data.pos_z !== e.pos_z) begin
          $error("pos_z exp %0d got %0d", e.pos_z, out_data.pos_z); fail_count++; end
        if (out_data.hit_on_x !== e.hit_on_x) begin
          $error("hit_on_x exp %0d got %0d", e.hit_on_x, out_data.hit_on_x); fail_count++; end
        if (out_data.hit_on_y !== e.hit_on_y) begin
          $error("hit_on_y exp %0d got %0d", e.hit_on_y, out_data.hit_on_y); fail_count++; end
        if (out_data.hit_on_z !== e.hit_on_z) begin
          $error("hit_on_z exp %0d got %0d", e.hit_on_z, out_data.hit_on_z); fail_count++; end
        if (out_data.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_data.last); fail_count++; end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Directed stimulus: one table row per beat, with a hand-written final where obvious
  typedef struct {
    saar_pkg::in_item_t  item;
    bit                  has_final;
    saar_pkg::res_item_t final_beat;
  } stim_row_t;

  function automatic saar_pkg::res_item_t plain_final(longint x, longint y, longint z);
    saar_pkg::res_item_t r;
    r = '0;
    r.is_final = 1'b1; r.last = 1'b1;
    r.pos_x = x[31:0]; r.pos_y = y[31:0]; r.pos_z = z[31:0];
    return r;
  endfunction

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    saar_pkg::res_item_t got_final;
    int        k;
    longint    mx, mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;

    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    fail_count = 0; cycle_count = 0; calm = 1'b0; hold_off = 0;
    seen_mask = '0;
    for (int i = 0; i < saar_pkg::NUM_ENTRIES; i++) begin
      box_kind[i] = saar_pkg::KIND_NONE;
      for (int a = 0; a < 3; a++) begin box_pos[a][i] = 0; box_half[a][i] = 0; end
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table after reset: inactive and active movers just move
    row = '{make_item(saar_pkg::OP_CHECK, 0, 100, 200, 300, 5, -5, 7, 64, 64, 64,
                      saar_pkg::KIND_SOLID), 1, plain_final(105, 195, 307)};
    rows.push_back(row);
    row = '{make_item(saar_pkg::OP_CHECK, 3, mx, mn, 0, mx, mn, 0, 0, 0, 0,
                      saar_pkg::KIND_NONE), 1, plain_final(mx, mn, 0)};
    rows.push_back(row);
    // Load extremes, saturating stored centres, and ignored sizes' low bits
    row = '{make_item(saar_pkg::OP_LOAD, 15, mx, mn, mn, mx, mn, -1,
                      'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 2), 0, '0};
    rows.push_back(row);
    row = '{make_item(saar_pkg::OP_LOAD, 1, 1000, 0, 0, 0, 0, 0, 512, 512, 512,
                      saar_pkg::KIND_SOLID), 0, '0};
    rows.push_back(row);
    row = '{make_item(saar_pkg::OP_LOAD, 2, 0, 1000, 0, 0, 0, 0, 512, 512, 512, 2), 0, '0};
    rows.push_back(row);
    row = '{make_item(saar_pkg::OP_LOAD, 4, 0, 0, 1000, 0, 0, 0, 511, 513, 512, 3), 0, '0};
    rows.push_back(row);
    row = '{make_item(saar_pkg::OP_LOAD, 5, -1000, 0, 0, 0, 0, 0, 400, 400, 400,
                      saar_pkg::KIND_SOLID), 0, '0};
    rows.push_back(row);
    // Solid mover clamped on X, overlap-only, kind three, inactive and own slot skips
    row = '{make_item(saar_pkg::OP_CHECK, 0, 0, 0, 0, 1000, 0, 0, 512, 512, 512,
                      saar_pkg::KIND_SOLID), 0, '0};
    rows.push_back(row);
    row = '{make_item(saar_pkg::OP_CHECK, 0, 0, 0, 0, -1000, 0, 0, 512, 512, 512,
                      saar_pkg::KIND_SOLID), 0, '0};
    rows.push_back(row);
    row = '{make_item(saar_pkg::OP_CHECK, 1, 0, 0, 0, 1000, 1000, 1000, 600, 600, 600, 2),
            0, '0};
    rows.push_back(row);
    row = '{make_item(saar_pkg::OP_CHECK, 7, 0, 0, 0, 0, 900, 900, 600, 600, 600, 3), 0, '0};
    rows.push_back(row);
    row = '{make_item(saar_pkg::OP_CHECK, 4, 0, 0, 0, 0, 0, 1000, 600, 600, 600,
                      saar_pkg::KIND_SOLID), 0, '0};
    rows.push_back(row);
    row = '{make_item(saar_pkg::OP_CHECK, 2, 1000, 1000, 1000, 0, 0, 0,
                      'hFFFFFF, 'hFFFFFF, 'hFFFFFF, saar_pkg::KIND_SOLID), 0, '0};
    rows.push_back(row);
    row = '{make_item(saar_pkg::OP_CHECK, 9, mn, mx, mx, mn, mx, mx,
                      'hFFFFFF, 'hFFFFFF, 'hFFFFFF, saar_pkg::KIND_SOLID), 0, '0};
    rows.push_back(row);
    row = '{make_item(saar_pkg::OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 2048, 2048, 2048,
                      saar_pkg::KIND_NONE), 1, plain_final(0, 0, 0)};
    rows.push_back(row);
    // Deactivate an entry, then check again
    row = '{make_item(saar_pkg::OP_LOAD, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, saar_pkg::KIND_NONE),
            0, '0};
    rows.push_back(row);
    row = '{make_item(saar_pkg::OP_CHECK, 0, 0, 0, 0, 1000, 0, 0, 512, 512, 512,
                      saar_pkg::KIND_SOLID), 0, '0};
    rows.push_back(row);

    foreach (rows[r]) begin
      send_beat(rows[r].item, 1'b1);
      if (rows[r].has_final) begin
        got_final = expected_beats[$];
        if (got_final !== rows[r].final_beat) begin
          $error("directed row %0d: predicted final %p, table says %p",
                 r, got_final, rows[r].final_beat);
          fail_count++;
        end
      end
    end

    // Back-pressure: receiver refuses for a long stretch while checks keep coming
    hold_off <= 400;
    for (int n = 0; n < 6; n++) begin
      send_beat(random_item(saar_pkg::OP_CHECK, $urandom_range(1, 3)), 1'b0);
    end
    in_valid <= 1'b0;
    // Sender pauses until everything has drained
    while (expected_beats.size() != 0) @(posedge clk);

    // Random part: a calm stretch in the middle, loads and checks mixed
    for (int n = 0; n < 100; n++) begin
      calm = (n >= 40 && n < 60);
      k = $urandom_range(0, 3);
      if ($urandom_range(0, 99) < 45) begin
        send_beat(random_item(saar_pkg::OP_LOAD, k), 1'b1);
      end else begin
        send_beat(random_item(saar_pkg::OP_CHECK, k), 1'b1);
      end
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
